// ===== src/madr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package madr_pkg;

  // Widths of the fixed-point sample and the dead band register
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned DEAD_BAND_W = 12;

  // Dead band after reset: about 0.05 in Q11.12
  localparam logic [DEAD_BAND_W-1:0] DEAD_BAND_RESET = 12'd205;

endpackage

`default_nettype wire

// ===== src/madr_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Divide a signed window sum by the window length, truncating toward zero.
// The division is a multiply by a scaled reciprocal of the constant length;
// the reciprocal is large enough that the quotient of the magnitude is exact.
module madr_div
  import madr_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 8,
  parameter int unsigned SUM_W      = 27
) (
  input  wire logic signed [SUM_W-1:0]    sum,
  output logic signed [SAMPLE_W-1:0]      quotient
);

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
  localparam int unsigned SHIFT = SUM_W + IDX_W;
  localparam int unsigned MUL_W = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + MUL_W;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / 64'(WINDOW_LEN)) + 64'd1;
  localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

  logic                    neg;
  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod;
  logic [SAMPLE_W-1:0]     mag_q;

  // Take the magnitude, scale it and restore the sign
  always_comb begin
    neg      = sum[SUM_W-1];
    mag      = neg ? SUM_W'(-sum) : SUM_W'(sum);
    prod     = PROD_W'(mag) * PROD_W'(RECIP);
    mag_q    = prod[SHIFT +: SAMPLE_W];
    quotient = neg ? SAMPLE_W'(-mag_q) : SAMPLE_W'(mag_q);
  end

endmodule

`default_nettype wire

// ===== src/moving_average_deadband_reset_unit.sv =====
// Moving average over the last WINDOW_LEN samples with a dead band clear.
// Pipeline: the window state and sum are registered at input accept; the divide of
// the held sum goes into the result register when that register is free.
// Throughput: one item per cycle while out_ready holds; input stays ready while the
// result register drains, the window read is prefetched one slot ahead of the write.
// Reset (rst_n, synchronous): window empty, sum zero, dead band 205, no item held.
`timescale 1ns / 1ps
`default_nettype none

module moving_average_deadband_reset_unit
  import madr_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [DEAD_BAND_W-1:0]     cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [SAMPLE_W-1:0]      out_average,
  output logic                            out_was_cleared
);

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W = SAMPLE_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

  logic [DEAD_BAND_W-1:0]      dead_band_r;
  logic signed [SAMPLE_W-1:0]  mem [WINDOW_LEN];
  logic signed [SAMPLE_W-1:0]  old_r;
  logic [WINDOW_LEN-1:0]       valid_r, valid_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic signed [SUM_W-1:0]     sum_r, sum_nxt;
  logic                        s1_valid_r, s1_clr_r;
  logic                        out_valid_r, out_clr_r;
  logic signed [SAMPLE_W-1:0]  out_avg_r;
  logic signed [SAMPLE_W-1:0]  quotient;

  logic                        accept, adv_out, s1_move, clear;
  logic [IDX_W-1:0]            wr_idx, rd_idx, after_wr;
  logic [SAMPLE_W-1:0]         sample_mag;
  logic signed [SAMPLE_W-1:0]  old_val;

  // Handshake: stage one moves whenever the result register is free
  assign adv_out  = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && adv_out;
  assign in_ready = !s1_valid_r || adv_out;
  assign accept   = in_valid && in_ready;

  // Ring positions: the slot written now and the one to prefetch
  always_comb begin
    wr_idx   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
    after_wr = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
    rd_idx   = accept ? after_wr : wr_idx;
  end

  // Dead band test and running sum update
  always_comb begin
    sample_mag = in_sample[SAMPLE_W-1] ? SAMPLE_W'(-in_sample) : SAMPLE_W'(in_sample);
    clear      = sample_mag < SAMPLE_W'(dead_band_r);
    old_val    = valid_r[wr_idx] ? old_r : '0;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    valid_nxt  = valid_r;
    if (accept) begin
      idx_nxt = wr_idx;
      if (clear) begin
        sum_nxt   = '0;
        valid_nxt = '0;
      end else begin
        sum_nxt           = sum_r - SUM_W'(old_val) + SUM_W'(in_sample);
        valid_nxt[wr_idx] = 1'b1;
      end
    end
  end

  // Window memory: write the new item, prefetch the next slot to retire
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_idx] <= in_sample;
    end
    old_r <= mem[rd_idx];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_band_r <= DEAD_BAND_RESET;
    end else if (cfg_wr_en) begin
      dead_band_r <= cfg_wr_data;
    end
  end

  // Window state and stage one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      sum_r      <= '0;
      valid_r    <= '0;
      s1_valid_r <= 1'b0;
      s1_clr_r   <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
      valid_r <= valid_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
        s1_clr_r   <= clear;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Divide the held sum by the window length
  madr_div #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_div (
    .sum      (sum_r),
    .quotient (quotient)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_avg_r <= s1_clr_r ? '0 : quotient;
      out_clr_r <= s1_clr_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_average     = out_avg_r;
  assign out_was_cleared = out_clr_r;

  // Checks
  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    accept && clear |=> sum_r == '0 && valid_r == '0)
    else $error("dead band clear left window state behind");

  a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST_IDX)
    else $error("ring index beyond window length");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv_out |=> s1_valid_r && $stable(sum_r) && $stable(s1_clr_r))
    else $error("stalled stage one lost its item");

  a_cleared_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clr_r |-> out_avg_r == '0)
    else $error("cleared item carries a nonzero average");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import madr_pkg::*;

  localparam int WINDOW_LEN      = 8;
  localparam int SLOT_W          = $clog2(WINDOW_LEN);
  localparam int SUM_W           = SAMPLE_W + SLOT_W;
  localparam int SETTLE_CYCLES   = 8;
  localparam int STALL_LIMIT     = 1000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int FINAL_ITEMS     = 250;
  localparam int REPORT_CAP      = 100;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [DEAD_BAND_W-1:0]     BAND_MAX   = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       was_cleared;
  } window_mean_t;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       cfg_wr_en       = 1'b0;
  logic [DEAD_BAND_W-1:0]     cfg_wr_data     = '0;
  logic                       in_valid        = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample       = '0;
  logic                       out_valid;
  logic                       out_ready       = 1'b1;
  logic signed [SAMPLE_W-1:0] out_average;
  logic                       out_was_cleared;

  // Shadow state of the filter
  logic signed [SAMPLE_W-1:0] model_window [WINDOW_LEN] = '{default: '0};
  logic [SLOT_W-1:0]          model_slot      = '0;
  logic signed [SUM_W-1:0]    model_sum       = '0;
  logic [DEAD_BAND_W-1:0]     model_dead_band = DEAD_BAND_RESET;

  window_mean_t pending_averages [$];
  int           mismatches  = 0;
  int           idle_cycles = 0;
  int           stall_left  = 0;
  bit           idle_on     = 1'b1;

  moving_average_deadband_reset_unit #(
    .WINDOW_LEN(WINDOW_LEN)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_average    (out_average),
    .out_was_cleared(out_was_cleared)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the shadow window by one sample and return the mean it produces
  function automatic window_mean_t advance_window(input logic signed [SAMPLE_W-1:0] value);
    window_mean_t            result;
    logic signed [SAMPLE_W:0] wide;
    logic [SAMPLE_W:0]       magnitude;
    logic signed [SUM_W-1:0] quotient;
    wide      = (SAMPLE_W+1)'(value);
    magnitude = (wide < 0) ? -wide : wide;
    model_slot = (model_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : model_slot + 1'b1;
    model_sum = model_sum - model_window[model_slot];
    model_window[model_slot] = value;
    if (magnitude < model_dead_band) begin
      // Inside the dead band: drop the whole window
      foreach (model_window[i]) model_window[i] = '0;
      model_sum          = '0;
      result.average     = '0;
      result.was_cleared = 1'b1;
    end else begin
      model_sum          = model_sum + value;
      quotient           = SUM_W'(model_sum / WINDOW_LEN);
      result.average     = quotient[SAMPLE_W-1:0];
      result.was_cleared = 1'b0;
    end
    return result;
  endfunction

  // Mostly full-range values, some near the band edge, a few extremes
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W:0] near;
    logic signed [SAMPLE_W:0] band;
    logic [31:0]              raw;
    band = (SAMPLE_W+1)'({1'b0, model_dead_band});
    raw  = $urandom;
    case ($urandom_range(0, 9))
      0, 1: begin
        near = (SAMPLE_W+1)'($urandom_range(0, 2 * model_dead_band + 1));
        if (raw[0]) near = -near;
        return near[SAMPLE_W-1:0];
      end
      2: begin
        case ($urandom_range(0, 5))
          0: near = (SAMPLE_W+1)'(SAMPLE_MAX);
          1: near = (SAMPLE_W+1)'(SAMPLE_MIN);
          2: near = band;
          3: near = -band;
          4: near = (SAMPLE_W+1)'(band - 1);
          default: near = (SAMPLE_W+1)'(1 - band);
        endcase
        return near[SAMPLE_W-1:0];
      end
      default: return raw[SAMPLE_W-1:0];
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < REPORT_CAP) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one item, hold it until accepted, then maybe idle for a burst
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (!in_ready);
    pending_averages.push_back(advance_window(value));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain all outstanding results, then update the dead band
  task automatic write_dead_band(input logic [DEAD_BAND_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    model_dead_band = value;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(pick_sample());
  endtask

  // Magnitudes just inside, on and outside the reset band; zero clears
  task automatic test_band_edges();
    send_sample(24'sd204);
    send_sample(-24'sd204);
    send_sample(24'sd205);
    send_sample(-24'sd205);
    send_sample(24'sd206);
    send_sample(24'sd0);
  endtask

  // Fill the window with the largest and then the most negative sample
  task automatic test_full_scale();
    repeat (WINDOW_LEN) send_sample(SAMPLE_MAX);
    repeat (WINDOW_LEN) send_sample(SAMPLE_MIN);
  endtask

  // With a zero band nothing clears, not even a zero sample
  task automatic test_zero_band();
    write_dead_band('0);
    send_sample(24'sd0);
    send_sample(24'sd1);
    send_sample(-24'sd1);
  endtask

  task automatic test_random_bands();
    logic [DEAD_BAND_W-1:0] bands [6];
    bands = '{BAND_MAX, '0, 12'd1, DEAD_BAND_RESET, 12'd0, 12'd0};
    bands[4] = DEAD_BAND_W'($urandom);
    bands[5] = DEAD_BAND_W'($urandom_range(1, 300));
    foreach (bands[i]) begin
      write_dead_band(bands[i]);
      send_random(ITEMS_PER_PHASE);
    end
  endtask

  // Last stretch: both sides always ready
  task automatic test_back_to_back();
    logic [DEAD_BAND_W-1:0] band;
    band = DEAD_BAND_W'($urandom_range(0, 1023));
    write_dead_band(band);
    idle_on = 1'b0;
    send_random(FINAL_ITEMS);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_band_edges();
    test_full_scale();
    test_zero_band();
    test_random_bands();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("moving_average_deadband_reset_unit test passed");
    end else begin
      $display("moving_average_deadband_reset_unit test failed");
    end
    $finish;
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expected mean
  always @(posedge clk) begin
    window_mean_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_averages.size() == 0) begin
        report_mismatch($sformatf("unexpected result average=%0d was_cleared=%0b",
                                  out_average, out_was_cleared));
      end else begin
        want = pending_averages.pop_front();
        if (out_average !== want.average)
          report_mismatch($sformatf("average %0d, expected %0d", out_average, want.average));
        if (out_was_cleared !== want.was_cleared)
          report_mismatch($sformatf("was_cleared %0b, expected %0b",
                                    out_was_cleared, want.was_cleared));
      end
    end
  end

  // Abort when no item moves on either side for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("moving_average_deadband_reset_unit test failed");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
src/madr_pkg.sv
src/madr_div.sv
src/moving_average_deadband_reset_unit.sv
verif/testbench.sv
